// ----- rtl/rev_pkg.sv -----
// Shared types and constants for the rotary encoder volume control.
// Holds the request/response word layouts, rotation codes and CSR indexes.
// No dependencies.
package rev_pkg;

   localparam int VOLUME_WIDTH    = 8;
   localparam int MODE_WIDTH      = 3;
   localparam int MASK_WIDTH      = 4;
   localparam int OUT_CHANNELS    = 4;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam int DEFAULT_CHANNELS = 4;

   localparam logic [VOLUME_WIDTH-1:0] MAX_VOLUME_RESET = 8'd255;
   localparam logic [VOLUME_WIDTH-1:0] STEP_SIZE_RESET  = 8'd5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_VOLUME = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_SIZE  = 1'd1;

   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_UP   = 2'd1,
      ROT_DOWN = 2'd2
   } rotation_type;

   typedef struct packed {
      logic pin_a;
      logic pin_b;
      logic key_n;
   } req_type;

   typedef struct packed {
      rotation_type            rotation;
      logic [MODE_WIDTH-1:0]   mode;
      logic [VOLUME_WIDTH-1:0] volume_ch0;
      logic [VOLUME_WIDTH-1:0] volume_ch1;
      logic [VOLUME_WIDTH-1:0] volume_ch2;
      logic [VOLUME_WIDTH-1:0] volume_ch3;
      logic [MASK_WIDTH-1:0]   write_mask;
   } rsp_type;

endpackage

// ----- rtl/rev_chan_if.sv -----
// Valid/ready channel carrying one word per handshake.
// Word type is a parameter; used with rev_pkg request and response types.
interface rev_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/rotary_encoder_volume_control.sv -----
// Rotary encoder volume control: quadrature detent decoder, mode key and
// saturating per-channel volume registers. Depends on rev_pkg and rev_chan_if.
//
// Usage:
//   req_chan carries one sample word per encoder tick (pin_a, pin_b, key_n).
//   rsp_chan returns exactly one word per sample: detected rotation, mode
//   after the tick, all four channel volumes and the mask of written channels.
//   csr_* writes max_volume (index 0) and step_size (index 1); write only
//   while no sample is in flight.
// Timing:
//   A sample is captured in an input register, evaluated against the decoder
//   state by one saturating add/compare, and lands in the output register,
//   which drives rsp_chan.valid.
//   Throughput is 1 word per cycle while rsp_chan.ready is high; the two
//   registers let a new sample enter while a finished word waits on the output.
// Reset:
//   Synchronous reset empties both stages, clears the decoder and mode,
//   zeroes all volumes and loads max_volume 255 and step_size 5.
// Stall:
//   With rsp_chan.ready low the output word holds; one more sample is taken
//   into the input register, after which req_chan.ready drops.
module rotary_encoder_volume_control #(
   parameter int CHANNELS = rev_pkg::DEFAULT_CHANNELS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rev_chan_if.sink                             req_chan,
   rev_chan_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [rev_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rev_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import rev_pkg::*;

   localparam int ModeBits = $clog2(CHANNELS + 1);

   logic                    in_valid_ff;
   req_type                 in_word_ff;
   logic                    out_valid_ff;
   rsp_type                 out_word_ff;
   rsp_type                 out_word_in;

   logic                    prev_a_ff, prev_a_in;
   logic                    prev_b_ff, prev_b_in;
   logic                    armed_ff, armed_in;
   logic                    key_prev_ff;
   logic [ModeBits-1:0]     mode_ff, mode_in;
   logic [VOLUME_WIDTH-1:0] volume_ff [CHANNELS];
   logic [VOLUME_WIDTH-1:0] volume_in [CHANNELS];
   logic [VOLUME_WIDTH-1:0] max_volume_ff;
   logic [VOLUME_WIDTH-1:0] step_size_ff;

   rotation_type            rotation;
   logic [MASK_WIDTH-1:0]   write_mask;
   logic [VOLUME_WIDTH-1:0] out_volume [OUT_CHANNELS];
   logic                    advance;
   logic                    fire;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

   always_comb begin
      logic [VOLUME_WIDTH:0] sum;
      logic                  key;
      logic                  a;
      logic                  b;
      key       = in_word_ff.key_n;
      a         = in_word_ff.pin_a;
      b         = in_word_ff.pin_b;
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      armed_in  = armed_ff;
      mode_in   = mode_ff;
      rotation  = ROT_NONE;
      write_mask = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         volume_in[k] = volume_ff[k];
      end
      if (key) begin
         if (!key_prev_ff) begin
            mode_in = (mode_ff >= ModeBits'(CHANNELS)) ? '0 : mode_ff + 1'b1;
         end
         if (a && b) begin
            armed_in = 1'b1;
         end
         if (armed_in && !a && !b) begin
            if (prev_a_ff) begin
               rotation = ROT_UP;
               armed_in = 1'b0;
            end else if (prev_b_ff) begin
               rotation = ROT_DOWN;
               armed_in = 1'b0;
            end
         end
         prev_a_in = a;
         prev_b_in = b;
      end
      for (int k = 0; k < CHANNELS; k++) begin
         sum = {1'b0, volume_ff[k]} + {1'b0, step_size_ff};
         if (rotation != ROT_NONE && (mode_in == '0 || mode_in == ModeBits'(k + 1))) begin
            if (rotation == ROT_UP) begin
               volume_in[k] = (sum > {1'b0, max_volume_ff}) ? max_volume_ff
                                                            : sum[VOLUME_WIDTH-1:0];
            end else begin
               volume_in[k] = (volume_ff[k] >= step_size_ff) ? volume_ff[k] - step_size_ff
                                                             : '0;
            end
            if (k < MASK_WIDTH) begin
               write_mask[k] = 1'b1;
            end
         end
      end
      for (int k = 0; k < OUT_CHANNELS; k++) begin
         out_volume[k] = '0;
         if (k < CHANNELS) begin
            out_volume[k] = volume_in[k];
         end
      end
      out_word_in.rotation   = rotation;
      out_word_in.mode       = MODE_WIDTH'(mode_in);
      out_word_in.volume_ch0 = out_volume[0];
      out_word_in.volume_ch1 = out_volume[1];
      out_word_in.volume_ch2 = out_volume[2];
      out_word_in.volume_ch3 = out_volume[3];
      out_word_in.write_mask = write_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_a_ff     <= 1'b0;
         prev_b_ff     <= 1'b0;
         armed_ff      <= 1'b0;
         key_prev_ff   <= 1'b1;
         mode_ff       <= '0;
         max_volume_ff <= MAX_VOLUME_RESET;
         step_size_ff  <= STEP_SIZE_RESET;
         for (int k = 0; k < CHANNELS; k++) begin
            volume_ff[k] <= '0;
         end
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            prev_a_ff   <= prev_a_in;
            prev_b_ff   <= prev_b_in;
            armed_ff    <= armed_in;
            key_prev_ff <= in_word_ff.key_n;
            mode_ff     <= mode_in;
            for (int k = 0; k < CHANNELS; k++) begin
               volume_ff[k] <= volume_in[k];
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_VOLUME: max_volume_ff <= csr_data;
               CSR_STEP_SIZE:  step_size_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_word_ff <= req_chan.payload;
      end
      if (fire) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

// ----- rtl/rev_checker.sv -----
// Port-level checks for rotary_encoder_volume_control.
// Depends on rev_pkg; attached to the top level by the bind below.
module rev_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rev_pkg::rsp_type rsp_word
);
   import rev_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.rotation == ROT_NONE |-> rsp_word.write_mask == '0)
      else $error("channel written without a detent");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.mode != '0 |-> $onehot0(rsp_word.write_mask))
      else $error("single-channel mode wrote several channels");

endmodule

bind rotary_encoder_volume_control rev_checker u_rev_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.payload)
);

// ----- test/rotary_encoder_volume_control_tb.sv -----
// Testbench for rotary_encoder_volume_control: drives encoder/key sample words,
// predicts every response word and checks each field. Depends on rev_pkg and
// rev_chan_if.
`timescale 1ns / 1ps

module rotary_encoder_volume_control_tb;
   import rev_pkg::*;

   localparam int CHANNEL_COUNT = DEFAULT_CHANNELS;
   localparam int REPORT_LIMIT  = 10;

   logic clock;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   rev_chan_if #(.word_type(req_type)) req_if ();
   rev_chan_if #(.word_type(rsp_type)) rsp_if ();

   rotary_encoder_volume_control u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   logic [VOLUME_WIDTH-1:0] limit_level;
   logic [VOLUME_WIDTH-1:0] step_level;
   logic                    last_a;
   logic                    last_b;
   logic                    detent_armed;
   logic                    key_seen;
   logic [MODE_WIDTH-1:0]   mode_sel;
   logic [VOLUME_WIDTH-1:0] level [OUT_CHANNELS];

   rsp_type     pending_volume_words [$];
   int unsigned mismatch_count;
   int unsigned samples_sent;
   int unsigned stall_left;
   bit          gaps_on;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic rsp_type predict_volume_word(req_type w);
      rsp_type      r;
      rotation_type turn;
      logic [VOLUME_WIDTH-1:0] mask;
      logic [VOLUME_WIDTH:0]   sum;
      turn = ROT_NONE;
      mask = '0;
      if (w.key_n) begin
         if (!key_seen)
            mode_sel = (mode_sel >= CHANNEL_COUNT) ? '0 : mode_sel + 1'b1;
         if (w.pin_a && w.pin_b)
            detent_armed = 1'b1;
         if (detent_armed && !w.pin_a && !w.pin_b) begin
            if (last_a)
               turn = ROT_UP;
            else if (last_b)
               turn = ROT_DOWN;
            if (turn != ROT_NONE)
               detent_armed = 1'b0;
         end
         last_a = w.pin_a;
         last_b = w.pin_b;
         if (turn != ROT_NONE) begin
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
               if (mode_sel == 0 || mode_sel == k + 1) begin
                  if (turn == ROT_UP) begin
                     sum = {1'b0, level[k]} + {1'b0, step_level};
                     level[k] = (sum > limit_level) ? limit_level : sum[VOLUME_WIDTH-1:0];
                  end else begin
                     level[k] = (level[k] >= step_level) ? level[k] - step_level : '0;
                  end
                  mask[k] = 1'b1;
               end
            end
         end
      end
      key_seen = w.key_n;
      r.rotation   = turn;
      r.mode       = mode_sel;
      r.volume_ch0 = level[0];
      r.volume_ch1 = level[1];
      r.volume_ch2 = level[2];
      r.volume_ch3 = level[3];
      r.write_mask = mask[MASK_WIDTH-1:0];
      return r;
   endfunction

   task automatic report_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
   endtask

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got)
         report_failure($sformatf("%s expected %0d got %0d", field, want, got));
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         limit_level  = MAX_VOLUME_RESET;
         step_level   = STEP_SIZE_RESET;
         last_a       = 1'b0;
         last_b       = 1'b0;
         detent_armed = 1'b0;
         key_seen     = 1'b1;
         mode_sel     = '0;
         for (int k = 0; k < OUT_CHANNELS; k++)
            level[k] = '0;
         pending_volume_words.delete();
      end else begin
         if (req_if.valid && req_if.ready)
            pending_volume_words.push_back(predict_volume_word(req_if.payload));
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_volume_words.size() == 0) begin
               report_failure("response word with nothing expected");
            end else begin
               want = pending_volume_words.pop_front();
               check_field("rotation", 32'(want.rotation), 32'(got.rotation));
               check_field("mode", 32'(want.mode), 32'(got.mode));
               check_field("volume_ch0", 32'(want.volume_ch0), 32'(got.volume_ch0));
               check_field("volume_ch1", 32'(want.volume_ch1), 32'(got.volume_ch1));
               check_field("volume_ch2", 32'(want.volume_ch2), 32'(got.volume_ch2));
               check_field("volume_ch3", 32'(want.volume_ch3), 32'(got.volume_ch3));
               check_field("write_mask", 32'(want.write_mask), 32'(got.write_mask));
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic req_type pins(logic a, logic b, logic key_n);
      req_type w;
      w.pin_a = a;
      w.pin_b = b;
      w.key_n = key_n;
      return w;
   endfunction

   task automatic send_sample(req_type w);
      int unsigned gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.payload <= w;
      do @(posedge clock); while (!req_if.ready);
      samples_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_volume_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_MAX_VOLUME)
         limit_level = value;
      else
         step_level = value;
   endtask

   task automatic test_reset_state();
      send_sample(pins(1'b0, 1'b0, 1'b1));
   endtask

   task automatic test_detent_direction();
      send_sample(pins(1'b1, 1'b1, 1'b1));
      send_sample(pins(1'b1, 1'b0, 1'b1));
      send_sample(pins(1'b0, 1'b0, 1'b1));
      repeat (2) begin
         send_sample(pins(1'b1, 1'b1, 1'b1));
         send_sample(pins(1'b0, 1'b1, 1'b1));
         send_sample(pins(1'b0, 1'b0, 1'b1));
      end
      send_sample(pins(1'b1, 1'b1, 1'b1));
      send_sample(pins(1'b0, 1'b0, 1'b1));
   endtask

   task automatic test_key_hold();
      send_sample(pins(1'b1, 1'b1, 1'b1));
      send_sample(pins(1'b0, 1'b0, 1'b0));
      send_sample(pins(1'b1, 1'b0, 1'b0));
      send_sample(pins(1'b0, 1'b0, 1'b1));
   endtask

   task automatic test_mode_wrap();
      repeat (CHANNEL_COUNT) begin
         send_sample(pins(1'b0, 1'b1, 1'b0));
         send_sample(pins(1'b0, 1'b0, 1'b1));
      end
   endtask

   task automatic send_turn(int unsigned up_percent);
      bit            up;
      logic [1:0]    ab;
      int unsigned   reps;
      up = $urandom_range(1, 100) <= up_percent;
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: ab = 2'b11;
            1: ab = up ? 2'b10 : 2'b01;
            2: ab = 2'b00;
            default: ab = up ? 2'b01 : 2'b10;
         endcase
         reps = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
         repeat (reps) send_sample(pins(ab[1], ab[0], 1'b1));
      end
   endtask

   task automatic send_key_press();
      repeat ($urandom_range(1, 3))
         send_sample(pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0));
      send_sample(pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1));
   endtask

   task automatic test_volume_levels(logic [CSR_DATA_WIDTH-1:0] max_level,
                                     logic [CSR_DATA_WIDTH-1:0] step,
                                     int unsigned up_percent,
                                     int unsigned count,
                                     bit allow_gaps);
      int unsigned first;
      int unsigned pick;
      drain_results();
      write_register(CSR_MAX_VOLUME, max_level);
      write_register(CSR_STEP_SIZE, step);
      gaps_on = allow_gaps;
      first = samples_sent;
      while (samples_sent - first < count) begin
         if (allow_gaps && $urandom_range(0, 15) == 0)
            gaps_on = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 19);
         if (pick < 14)
            send_turn(up_percent);
         else if (pick < 17)
            send_key_press();
         else
            repeat ($urandom_range(1, 4))
               send_sample(pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
      end
   endtask

   initial begin
      reset            = 1'b1;
      gaps_on          = 1'b0;
      mismatch_count   = 0;
      samples_sent     = 0;
      stall_left       = 0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MAX_VOLUME;
      csr_data         = '0;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      rsp_if.ready     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_detent_direction();
      test_key_hold();
      test_mode_wrap();

      test_volume_levels(8'd255, 8'd5, 70, 200, 1'b1);
      test_volume_levels(8'd0, 8'd1, 50, 200, 1'b1);
      test_volume_levels(8'd255, 8'd255, 50, 200, 1'b1);
      test_volume_levels(8'd100, 8'd7, 60, 200, 1'b1);
      test_volume_levels(8'd255, 8'd1, 80, 200, 1'b1);
      test_volume_levels(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                         50, 200, 1'b1);
      test_volume_levels(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                         50, 200, 1'b0);

      drain_results();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && pending_volume_words.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
